### hw/rtl/uart_baud_divisor_calc_top_assert.svh
// assertion macros shared by the baud divisor calculator modules
`ifndef UART_BAUD_DIVISOR_CALC_TOP_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UBDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubdc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define UBDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubdc assertion failed");

`endif

### hw/rtl/ubdc_pkg.sv
// types, constants and helpers for the baud divisor calculator
package ubdc_pkg;

    localparam int RATE_W = 24;
    localparam int DIV_W  = RATE_W;
    localparam int FAC_W  = 8;
    localparam int PRE_W  = 2;
    localparam int CODE_W = 3;
    localparam int IDX_W  = 16;

    localparam int unsigned CLK3_HZ = 6000000;
    localparam int unsigned CLK2_HZ = 750000;
    localparam int unsigned CLK1_HZ = 93750;
    localparam int unsigned CLK0_HZ = 11719;
    localparam int unsigned MAX_DIV = 255;

    localparam logic [RATE_W-1:0] THR3 = RATE_W'(CLK3_HZ / MAX_DIV);
    localparam logic [RATE_W-1:0] THR2 = RATE_W'(CLK2_HZ / MAX_DIV);
    localparam logic [RATE_W-1:0] THR1 = RATE_W'(CLK1_HZ / MAX_DIV);

    localparam logic [RATE_W-1:0] RATE_FAST = RATE_W'(921600);
    localparam logic [FAC_W-1:0]  FAC_FAST  = 8'hF3;
    localparam logic [RATE_W-1:0] RATE_MID  = RATE_W'(307200);
    localparam logic [FAC_W-1:0]  FAC_MID   = 8'hD9;

    localparam logic [CODE_W-1:0] EXACT_CODE = 3'd7;
    localparam logic [FAC_W-1:0]  IDX_FLAG   = 8'h80;

    typedef enum logic [PRE_W-1:0] {
        PRE_CLK0 = 2'd0,
        PRE_CLK1 = 2'd1,
        PRE_CLK2 = 2'd2,
        PRE_CLK3 = 2'd3
    } prescale_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        prescale_t         code;
        logic              special;
        logic [FAC_W-1:0]  sfac;
        logic              err;
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] div;
        side_t            side;
    } div_t;

    function automatic logic [DIV_W-1:0] clk_of(input prescale_t code);
        logic [DIV_W-1:0] hz;
        unique case (code)
            PRE_CLK3: hz = DIV_W'(CLK3_HZ);
            PRE_CLK2: hz = DIV_W'(CLK2_HZ);
            PRE_CLK1: hz = DIV_W'(CLK1_HZ);
            PRE_CLK0: hz = DIV_W'(CLK0_HZ);
            default:  hz = DIV_W'(CLK0_HZ);
        endcase
        return hz;
    endfunction

endpackage

### hw/rtl/ubdc_if.sv
// valid/ready channel interfaces for rate requests and divisor results
interface ubdc_req_if;
    logic                          valid;
    logic                          ready;
    logic [ubdc_pkg::RATE_W-1:0]   line_rate;

    modport source (output valid, output line_rate, input ready);
    modport sink   (input valid, input line_rate, output ready);
endinterface

interface ubdc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ubdc_pkg::FAC_W-1:0]    factor;
    logic [ubdc_pkg::PRE_W-1:0]    prescale;
    logic [ubdc_pkg::IDX_W-1:0]    index_word;
    logic                          error;

    modport source (output valid, output factor, output prescale, output index_word,
                    output error, input ready);
    modport sink   (input valid, input factor, input prescale, input index_word,
                    input error, output ready);
endinterface

### hw/rtl/uart_baud_divisor_calc_top.sv
// baud divisor calculator: clock select, divisor search with rounding, index word
// structure: 1 input register, 24 cells for rate division, two parallel rows of
//   24 cells for the two rounding divisions, 1 output register
// throughput: one transaction per cycle while results are taken; every cell carries
//   its own valid bit, so bubbles collapse and a stalled result only blocks when the row is full
// reset: asynchronous active-low reset clears all valid bits; no clearing pass
module uart_baud_divisor_calc_top (
    input logic          clk,
    input logic          rst_n,
    ubdc_req_if.sink     req,
    ubdc_rsp_if.source   rsp
);

    logic                          pre_valid_reg;
    ubdc_pkg::div_t                pre_data_reg;
    ubdc_pkg::div_t                pre_data_next;
    logic                          pre_ready;

    logic                          c1_in_ready;
    logic                          c1_out_valid;
    ubdc_pkg::div_t                c1_out;
    logic                          c2_in_ready;

    ubdc_pkg::side_t               mid_side;
    logic                          mid_bad;
    logic [ubdc_pkg::FAC_W-1:0]    mid_d;
    logic [ubdc_pkg::FAC_W-1:0]    mid_d1;
    ubdc_pkg::div_t                c2a_in;
    ubdc_pkg::div_t                c2b_in;

    logic                          c2a_in_ready;
    logic                          c2b_in_ready;
    logic                          c2a_out_valid;
    logic                          c2b_out_valid;
    ubdc_pkg::div_t                c2a_out;
    ubdc_pkg::div_t                c2b_out;
    logic                          c2_out_ready;

    logic [ubdc_pkg::DIV_W:0]      post_sum;
    logic                          post_inc;
    logic [ubdc_pkg::FAC_W-1:0]    post_dd;
    logic [ubdc_pkg::FAC_W-1:0]    post_fac;

    logic                          out_valid_reg;
    logic [ubdc_pkg::FAC_W-1:0]    out_fac_reg;
    logic [ubdc_pkg::FAC_W-1:0]    out_fac_next;
    logic [ubdc_pkg::PRE_W-1:0]    out_pre_reg;
    logic [ubdc_pkg::PRE_W-1:0]    out_pre_next;
    logic [ubdc_pkg::IDX_W-1:0]    out_idx_reg;
    logic [ubdc_pkg::IDX_W-1:0]    out_idx_next;
    logic                          out_err_reg;
    logic                          out_err_next;

    // input stage: clock select and special-rate decode
    assign pre_ready = !pre_valid_reg || c1_in_ready;
    assign req.ready = pre_ready;

    always_comb
    begin
        pre_data_next.side.rate    = req.line_rate;
        pre_data_next.side.special = 1'b0;
        pre_data_next.side.sfac    = ubdc_pkg::FAC_FAST;
        pre_data_next.side.err     = (req.line_rate == '0);
        if (req.line_rate == ubdc_pkg::RATE_FAST)
        begin
            pre_data_next.side.special = 1'b1;
            pre_data_next.side.sfac    = ubdc_pkg::FAC_FAST;
        end
        else if (req.line_rate == ubdc_pkg::RATE_MID)
        begin
            pre_data_next.side.special = 1'b1;
            pre_data_next.side.sfac    = ubdc_pkg::FAC_MID;
        end
        if (req.line_rate > ubdc_pkg::THR3)
        begin
            pre_data_next.side.code = ubdc_pkg::PRE_CLK3;
        end
        else if (req.line_rate > ubdc_pkg::THR2)
        begin
            pre_data_next.side.code = ubdc_pkg::PRE_CLK2;
        end
        else if (req.line_rate > ubdc_pkg::THR1)
        begin
            pre_data_next.side.code = ubdc_pkg::PRE_CLK1;
        end
        else
        begin
            pre_data_next.side.code = ubdc_pkg::PRE_CLK0;
        end
        pre_data_next.num = ubdc_pkg::clk_of(pre_data_next.side.code);
        pre_data_next.rem = '0;
        pre_data_next.quo = '0;
        pre_data_next.div = req.line_rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (pre_ready)
        begin
            pre_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && pre_ready)
        begin
            pre_data_reg <= pre_data_next;
        end
    end

    // clock / rate
    ubdc_div_chain u_rate_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid_reg),
        .in_ready  (c1_in_ready),
        .in_data   (pre_data_reg),
        .out_valid (c1_out_valid),
        .out_ready (c2_in_ready),
        .out_data  (c1_out)
    );

    // divisor range check and rounding divisions setup
    always_comb
    begin
        mid_bad      = (c1_out.quo == '0) ||
                       (c1_out.quo >= ubdc_pkg::DIV_W'(ubdc_pkg::MAX_DIV));
        mid_side     = c1_out.side;
        mid_side.err = c1_out.side.err || mid_bad;
        mid_d        = c1_out.quo[ubdc_pkg::FAC_W-1:0];
        mid_d1       = mid_d + 8'd1;
        c2a_in.num   = ubdc_pkg::clk_of(c1_out.side.code);
        c2a_in.rem   = '0;
        c2a_in.quo   = '0;
        c2a_in.div   = ubdc_pkg::DIV_W'(mid_d);
        c2a_in.side  = mid_side;
        c2b_in       = c2a_in;
        c2b_in.div   = ubdc_pkg::DIV_W'(mid_d1);
    end

    assign c2_in_ready = c2a_in_ready;

    // clock / d
    ubdc_div_chain u_lo_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_out_valid),
        .in_ready  (c2a_in_ready),
        .in_data   (c2a_in),
        .out_valid (c2a_out_valid),
        .out_ready (c2_out_ready),
        .out_data  (c2a_out)
    );

    // clock / (d + 1)
    ubdc_div_chain u_hi_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_out_valid),
        .in_ready  (c2b_in_ready),
        .in_data   (c2b_in),
        .out_valid (c2b_out_valid),
        .out_ready (c2_out_ready),
        .out_data  (c2b_out)
    );

    // round to nearer achievable rate, or pass a special or error result, and pack the result
    assign c2_out_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        post_sum = {1'b0, c2a_out.quo} + {1'b0, c2b_out.quo};
        post_inc = post_sum > {c2a_out.side.rate, 1'b0};
        post_dd  = c2a_out.div[ubdc_pkg::FAC_W-1:0] +
                   {{(ubdc_pkg::FAC_W-1){1'b0}}, post_inc};
        post_fac = ~post_dd + 8'd1;
        if (c2a_out.side.special)
        begin
            out_fac_next = c2a_out.side.sfac;
            out_pre_next = ubdc_pkg::EXACT_CODE[ubdc_pkg::PRE_W-1:0];
            out_idx_next = {c2a_out.side.sfac,
                            ubdc_pkg::IDX_FLAG | ubdc_pkg::FAC_W'(ubdc_pkg::EXACT_CODE)};
            out_err_next = 1'b0;
        end
        else if (c2a_out.side.err)
        begin
            out_fac_next = '0;
            out_pre_next = '0;
            out_idx_next = '0;
            out_err_next = 1'b1;
        end
        else
        begin
            out_fac_next = post_fac;
            out_pre_next = c2a_out.side.code;
            out_idx_next = {post_fac,
                            ubdc_pkg::IDX_FLAG | ubdc_pkg::FAC_W'(c2a_out.side.code)};
            out_err_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (c2_out_ready)
        begin
            out_valid_reg <= c2a_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c2a_out_valid && c2_out_ready)
        begin
            out_fac_reg <= out_fac_next;
            out_pre_reg <= out_pre_next;
            out_idx_reg <= out_idx_next;
            out_err_reg <= out_err_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.factor     = out_fac_reg;
    assign rsp.prescale   = out_pre_reg;
    assign rsp.index_word = out_idx_reg;
    assign rsp.error      = out_err_reg;

`include "uart_baud_divisor_calc_top_assert.svh"

    // the two rounding chains run in lockstep
    `UBDC_ASSERT_IMP(a_chain_lockstep, 1'b1,
        (c2a_in_ready == c2b_in_ready) && (c2a_out_valid == c2b_out_valid))
    `UBDC_ASSERT_IMP(a_chain_side_match, c2a_out_valid, c2a_out.side == c2b_out.side)
    // clock/d and clock/(d+1) bracket the requested rate
    `UBDC_ASSERT_IMP(a_rate_bracket,
        c2a_out_valid && !c2a_out.side.err && !c2a_out.side.special,
        (c2a_out.quo >= c2a_out.side.rate) && (c2b_out.quo < c2a_out.side.rate))
    // error results carry cleared fields
    `UBDC_ASSERT_IMP(a_err_clean, rsp.valid && rsp.error,
        (rsp.factor == '0) && (rsp.prescale == '0) && (rsp.index_word == '0))
    // an accepted transaction lands in the input stage
    `UBDC_ASSERT_NEXT(a_accept_loads, req.valid && req.ready, pre_valid_reg)

endmodule

### hw/rtl/ubdc_div_cell.sv
// one restoring-division cell: produces one quotient bit per transaction
module ubdc_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ubdc_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ubdc_pkg::div_t out_data
);

    logic                     valid_reg;
    ubdc_pkg::div_t           data_reg;
    ubdc_pkg::div_t           data_next;
    logic [ubdc_pkg::DIV_W:0] shifted;
    logic [ubdc_pkg::DIV_W:0] diff;
    logic                     ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        shifted   = {in_data.rem, in_data.num[ubdc_pkg::DIV_W-1]};
        diff      = shifted - {1'b0, in_data.div};
        ge        = !diff[ubdc_pkg::DIV_W];
        data_next = in_data;
        data_next.rem = ge ? diff[ubdc_pkg::DIV_W-1:0] : shifted[ubdc_pkg::DIV_W-1:0];
        data_next.num = {in_data.num[ubdc_pkg::DIV_W-2:0], 1'b0};
        data_next.quo = {in_data.quo[ubdc_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

`include "uart_baud_divisor_calc_top_assert.svh"

    // partial remainder must stay below the divisor
    `UBDC_ASSERT_IMP(a_rem_below_div, valid_reg && (data_reg.div != '0), data_reg.rem < data_reg.div)

endmodule

### hw/rtl/ubdc_div_chain.sv
// row of division cells giving a full quotient after DIV_W steps
module ubdc_div_chain (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ubdc_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ubdc_pkg::div_t out_data
);

    logic           v [ubdc_pkg::DIV_W+1];
    logic           r [ubdc_pkg::DIV_W+1];
    ubdc_pkg::div_t d [ubdc_pkg::DIV_W+1];

    assign v[0]      = in_valid;
    assign in_ready  = r[0];
    assign d[0]      = in_data;
    assign out_valid = v[ubdc_pkg::DIV_W];
    assign r[ubdc_pkg::DIV_W] = out_ready;
    assign out_data  = d[ubdc_pkg::DIV_W];

    for (genvar i = 0; i < ubdc_pkg::DIV_W; i++)
    begin : g_cell
        ubdc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[i]),
            .in_ready  (r[i]),
            .in_data   (d[i]),
            .out_valid (v[i+1]),
            .out_ready (r[i+1]),
            .out_data  (d[i+1])
        );
    end

endmodule
